// ===== hw/rtl/c_subset_tokenizer_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer unit.
// ---------------------------------------------------------------------------
`ifndef C_SUBSET_TOKENIZER_UNIT_DEFINES_SVH
`define C_SUBSET_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CTU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// Next-cycle implication, checked outside reset.
`define CTU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

// ===== hw/rtl/ctu_pkg.sv =====
// ---------------------------------------------------------------------------
// Tokenizer package
// Token kinds, scan modes, character codes and the result record.
// ---------------------------------------------------------------------------
package ctu_pkg;

	localparam int TOK_W  = 24;   // width of start, length and line fields
	localparam int CHAR_W = 8;
	localparam int WIN_W  = 48;   // first six identifier bytes

	typedef enum logic [4:0] {
		K_INT    = 5'd0,
		K_IF     = 5'd1,
		K_ELSE   = 5'd2,
		K_WHILE  = 5'd3,
		K_RETURN = 5'd4,
		K_NUMBER = 5'd5,
		K_IDENT  = 5'd6,
		K_PLUS   = 5'd7,
		K_MINUS  = 5'd8,
		K_STAR   = 5'd9,
		K_SLASH  = 5'd10,
		K_EQ     = 5'd11,
		K_NEQ    = 5'd12,
		K_LT     = 5'd13,
		K_GT     = 5'd14,
		K_LEQ    = 5'd15,
		K_GEQ    = 5'd16,
		K_ASSIGN = 5'd17,
		K_LPAREN = 5'd18,
		K_RPAREN = 5'd19,
		K_LBRACE = 5'd20,
		K_RBRACE = 5'd21,
		K_SEMI   = 5'd22,
		K_COMMA  = 5'd23,
		K_EOF    = 5'd24,
		K_ERROR  = 5'd25
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_NUMBER  = 4'd1,
		M_IDENT   = 4'd2,
		M_SLASH   = 4'd3,
		M_LT      = 4'd4,
		M_GT      = 4'd5,
		M_EQ      = 4'd6,
		M_BANG    = 4'd7,
		M_COMMENT = 4'd8,
		M_SKIP    = 4'd9
	} mode_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// keyword text, first byte in the low bits
	localparam logic [WIN_W-1:0] KW_INT    = 48'h00_00_00_74_6E_69;
	localparam logic [WIN_W-1:0] KW_IF     = 48'h00_00_00_00_66_69;
	localparam logic [WIN_W-1:0] KW_ELSE   = 48'h00_00_65_73_6C_65;
	localparam logic [WIN_W-1:0] KW_WHILE  = 48'h00_65_6C_69_68_77;
	localparam logic [WIN_W-1:0] KW_RETURN = 48'h6E_72_75_74_65_72;

	typedef struct packed {
		kind_t              kind;
		logic [TOK_W-1:0]   start;
		logic [TOK_W-1:0]   length;
		logic [TOK_W-1:0]   line;
		logic [CHAR_W-1:0]  bad_char;
		logic               last;
	} res_t;

	// results produced by one byte, oldest in res0
	typedef struct packed {
		logic [1:0] n;
		res_t       res0;
		res_t       res1;
	} push_t;

endpackage

// ===== hw/rtl/ctu_core.sv =====
// ---------------------------------------------------------------------------
// Tokenizer scan core
// Holds the scan state and turns one registered byte into up to two results.
// ---------------------------------------------------------------------------
module ctu_core import ctu_pkg::*; #(
	parameter int OFFSET_WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CHAR_W-1:0] in_char,
	output push_t            push
);

	localparam logic [OFFSET_WIDTH-1:0] OW_ONE = OFFSET_WIDTH'(1);
	localparam logic [OFFSET_WIDTH-1:0] OW_SIX = OFFSET_WIDTH'(6);

	mode_t                   mode_q, mode_d;
	logic [OFFSET_WIDTH-1:0] offset_q, offset_d;
	logic [OFFSET_WIDTH-1:0] line_q, line_d;
	logic [OFFSET_WIDTH-1:0] pstart_q, pstart_d;
	logic [OFFSET_WIDTH-1:0] plen_q, plen_d;
	logic [WIN_W-1:0]        window_q, window_d;

	// decode of the byte as if seen between tokens
	logic        f_restart, f_push, f_len1, f_nl, f_pend, f_word;
	kind_t       f_kind;
	logic [7:0]  f_bad;
	mode_t       f_mode;

	// result that closes the pending token
	logic                    p_push;
	kind_t                   p_kind;
	logic [OFFSET_WIDTH-1:0] p_len;
	logic [7:0]              p_bad;
	logic                    use_fresh, restart;
	res_t                    pend_res, fresh_res;

	function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] v);
		return (&v) ? v : v + OW_ONE;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
	endfunction

	function automatic kind_t word_kind(input logic [OFFSET_WIDTH-1:0] len,
			input logic [WIN_W-1:0] win);
		kind_t k;
		k = K_IDENT;
		if (len == OFFSET_WIDTH'(3) && win == KW_INT) k = K_INT;
		else if (len == OFFSET_WIDTH'(2) && win == KW_IF) k = K_IF;
		else if (len == OFFSET_WIDTH'(4) && win == KW_ELSE) k = K_ELSE;
		else if (len == OFFSET_WIDTH'(5) && win == KW_WHILE) k = K_WHILE;
		else if (len == OFFSET_WIDTH'(6) && win == KW_RETURN) k = K_RETURN;
		return k;
	endfunction

	always_comb begin
		f_restart = 1'b0;
		f_push    = 1'b0;
		f_len1    = 1'b0;
		f_nl      = 1'b0;
		f_pend    = 1'b0;
		f_word    = 1'b0;
		f_kind    = K_ERROR;
		f_bad     = CH_NUL;
		f_mode    = M_IDLE;
		if (in_char == CH_NUL) begin
			f_restart = 1'b1;
			f_push    = 1'b1;
			f_kind    = K_EOF;
		end else if (in_char == CH_SPACE || (in_char >= CH_TAB && in_char <= CH_CR)) begin
			f_nl = (in_char == CH_NL);
		end else begin
			f_pend = 1'b1;
			if (is_digit(in_char)) begin
				f_mode = M_NUMBER;
			end else if (is_alpha(in_char) || in_char == CH_USCORE) begin
				f_mode = M_IDENT;
				f_word = 1'b1;
			end else begin
				f_push = 1'b1;
				f_len1 = 1'b1;
				unique case (in_char)
					CH_SLASH:  begin f_push = 1'b0; f_mode = M_SLASH; end
					CH_LT:     begin f_push = 1'b0; f_mode = M_LT; end
					CH_GT:     begin f_push = 1'b0; f_mode = M_GT; end
					CH_EQ:     begin f_push = 1'b0; f_mode = M_EQ; end
					CH_BANG:   begin f_push = 1'b0; f_mode = M_BANG; end
					CH_PLUS:   f_kind = K_PLUS;
					CH_MINUS:  f_kind = K_MINUS;
					CH_STAR:   f_kind = K_STAR;
					CH_LPAREN: f_kind = K_LPAREN;
					CH_RPAREN: f_kind = K_RPAREN;
					CH_LBRACE: f_kind = K_LBRACE;
					CH_RBRACE: f_kind = K_RBRACE;
					CH_SEMI:   f_kind = K_SEMI;
					CH_COMMA:  f_kind = K_COMMA;
					default: begin
						// unexpected byte: report it and drop the rest of the source
						f_kind = K_ERROR;
						f_len1 = 1'b0;
						f_bad  = in_char;
						f_mode = M_SKIP;
					end
				endcase
			end
		end
	end

	always_comb begin
		mode_d    = mode_q;
		offset_d  = offset_q;
		line_d    = line_q;
		pstart_d  = pstart_q;
		plen_d    = plen_q;
		window_d  = window_q;
		p_push    = 1'b0;
		p_kind    = K_ERROR;
		p_len     = '0;
		p_bad     = CH_NUL;
		use_fresh = 1'b0;
		restart   = 1'b0;
		if (in_valid) begin
			unique case (mode_q) inside
				M_SKIP: begin
					restart = (in_char == CH_NUL);
				end
				M_COMMENT: begin
					use_fresh = (in_char == CH_NUL) || (in_char == CH_NL);
				end
				M_NUMBER: begin
					if (is_digit(in_char)) begin
						plen_d = sat_inc(plen_q);
					end else begin
						p_push    = 1'b1;
						p_kind    = K_NUMBER;
						p_len     = plen_q;
						use_fresh = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_alpha(in_char) || is_digit(in_char) || in_char == CH_USCORE) begin
						if (plen_q < OW_SIX)
							window_d = window_q | (WIN_W'(in_char) << {plen_q[2:0], 3'b000});
						plen_d = sat_inc(plen_q);
					end else begin
						p_push    = 1'b1;
						p_kind    = word_kind(plen_q, window_q);
						p_len     = plen_q;
						use_fresh = 1'b1;
					end
				end
				M_SLASH: begin
					if (in_char == CH_SLASH) begin
						mode_d = M_COMMENT;
					end else begin
						p_push    = 1'b1;
						p_kind    = K_SLASH;
						p_len     = OW_ONE;
						use_fresh = 1'b1;
					end
				end
				M_LT, M_GT, M_EQ: begin
					p_push = 1'b1;
					if (in_char == CH_EQ) begin
						p_kind = (mode_q == M_LT) ? K_LEQ : (mode_q == M_GT) ? K_GEQ : K_EQ;
						p_len  = OFFSET_WIDTH'(2);
						mode_d = M_IDLE;
					end else begin
						p_kind    = (mode_q == M_LT) ? K_LT : (mode_q == M_GT) ? K_GT : K_ASSIGN;
						p_len     = OW_ONE;
						use_fresh = 1'b1;
					end
				end
				M_BANG: begin
					p_push = 1'b1;
					if (in_char == CH_EQ) begin
						p_kind = K_NEQ;
						p_len  = OFFSET_WIDTH'(2);
						mode_d = M_IDLE;
					end else begin
						// lone bang
						p_kind  = K_ERROR;
						p_bad   = CH_BANG;
						mode_d  = M_SKIP;
						restart = (in_char == CH_NUL);
					end
				end
				default: begin
					use_fresh = 1'b1;
				end
			endcase

			if (use_fresh) begin
				mode_d  = f_mode;
				restart = f_restart;
				if (f_nl)
					line_d = sat_inc(line_q);
				if (f_pend) begin
					pstart_d = offset_q;
					plen_d   = OW_ONE;
				end
				if (f_word)
					window_d = WIN_W'(in_char);
			end

			if (restart) begin
				mode_d   = M_IDLE;
				offset_d = '0;
				line_d   = OW_ONE;
				pstart_d = '0;
				plen_d   = '0;
				window_d = '0;
			end else begin
				offset_d = sat_inc(offset_q);
			end
		end
	end

	always_comb begin
		pend_res.kind     = p_kind;
		pend_res.start    = TOK_W'(pstart_q);
		pend_res.length   = TOK_W'(p_len);
		pend_res.line     = TOK_W'(line_q);
		pend_res.bad_char = p_bad;
		pend_res.last     = 1'b0;

		fresh_res.kind     = f_kind;
		fresh_res.start    = TOK_W'(offset_q);
		fresh_res.length   = TOK_W'(f_len1);
		fresh_res.line     = TOK_W'(line_q);
		fresh_res.bad_char = f_bad;
		fresh_res.last     = 1'b1;

		push.res1 = fresh_res;
		if (p_push) begin
			push.res0      = pend_res;
			push.res0.last = !(use_fresh && f_push);
			push.n         = (use_fresh && f_push) ? 2'd2 : 2'd1;
		end else begin
			push.res0 = fresh_res;
			push.n    = {1'b0, use_fresh && f_push};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			offset_q <= '0;
			line_q   <= OW_ONE;
			pstart_q <= '0;
			plen_q   <= '0;
			window_q <= '0;
		end else begin
			mode_q   <= mode_d;
			offset_q <= offset_d;
			line_q   <= line_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			window_q <= window_d;
		end
	end

endmodule

// ===== hw/rtl/ctu_res_fifo.sv =====
// ---------------------------------------------------------------------------
// Tokenizer result queue
// Takes up to two results per cycle, pops one; user keeps DEPTH a power of 2.
// ---------------------------------------------------------------------------
module ctu_res_fifo import ctu_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  push_t                      push,
	input  logic                       pop,
	output res_t                       head,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	res_t             mem [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign head      = mem[rp_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wp_q] <= push.res0;
		if (push.n == 2'd2)
			mem[wp_q + PTR_W'(1)] <= push.res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PTR_W'(push.n);
			rp_q    <= rp_q + PTR_W'(do_pop);
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(do_pop);
		end
	end

endmodule

// ===== hw/rtl/c_subset_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// C subset tokenizer unit
// Streaming lexer: one source byte in per cycle while s_axis_tready is high, tokens out with position.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata                                   | tuser      | tlast
//  s_axis   | in  | char_code[7:0]                          | -          | -
//  m_axis   | out | start, length, line (24 each), bad_char | token_kind | last_of_run
//
//  Throughput is one byte per cycle while s_axis_tready stays high: the scan
//  state loop (mode, offset, line, pending token) closes through the scan core.
//  A byte is registered on acceptance (s1) and its results enter the result
//  queue at the next edge, from where they are presented on m_axis.
//  Results drain one per cycle while m_axis_tready is high; a byte that gives
//  two results adds one entry of backlog, and s_axis_tready drops only when the
//  queue could not take the two results of both the byte in s1 and a new byte.
//  Reset clears the scan state to the start of a new source and empties the
//  queue.
//
module c_subset_tokenizer_unit import ctu_pkg::*; #(
	parameter int OFFSET_WIDTH = 24,   // offset, line and length counters, 8..32
	parameter int FIFO_DEPTH   = 8     // result queue entries, power of two, >= 4
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [23:0] token_start, [47:24] token_length,
	                                    // [71:48] token_line, [79:72] bad_char
	output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
	output logic        m_axis_tlast    // last_of_run
);

`include "c_subset_tokenizer_unit_defines.svh"

	localparam int CNT_W = $clog2(FIFO_DEPTH+1);

	logic             valid_s1;
	logic [7:0]       char_s1;
	push_t            push;
	res_t             head;
	logic             not_empty;
	logic [CNT_W-1:0] fifo_count;
	logic [CNT_W:0]   committed;

	// entries already queued plus the worst case from the byte in s1
	assign committed     = (CNT_W+1)'(fifo_count) + (valid_s1 ? (CNT_W+1)'(2) : '0);
	assign s_axis_tready = (committed <= (CNT_W+1)'(FIFO_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			char_s1 <= s_axis_tdata;
	end

	ctu_core #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_char  (char_s1),
		.push     (push)
	);

	ctu_res_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_axis_tready),
		.head      (head),
		.not_empty (not_empty),
		.count     (fifo_count)
	);

	assign m_axis_tvalid = not_empty;
	assign m_axis_tdata  = {head.bad_char, head.line, head.length, head.start};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;

	// queue never overruns its storage
	`CTU_ASSERT_IMP(a_fifo_bound, clk, arst_n, 1'b1,
		fifo_count <= CNT_W'(FIFO_DEPTH))
	// a byte's results always fit in the space left when it was admitted
	`CTU_ASSERT_IMP(a_push_fits, clk, arst_n, valid_s1,
		(CNT_W+1)'(fifo_count) + (CNT_W+1)'(push.n) <= (CNT_W+1)'(FIFO_DEPTH))
	// no results without a byte in s1
	`CTU_ASSERT_IMP(a_no_spurious, clk, arst_n, !valid_s1, push.n == 2'd0)
	// run marker sits only on the final result of a byte
	`CTU_ASSERT_IMP(a_last_mark, clk, arst_n, push.n == 2'd2,
		!push.res0.last && push.res1.last)

endmodule
